/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define CHK_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define CHK_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/pstsu_pkg.sv */
package pstsu_pkg;

    localparam int PLANES     = 64;
    localparam int FRAC_BITS  = 16;
    localparam int PLANE_W    = $clog2(PLANES);
    localparam int CNT_W      = PLANE_W + 1;
    localparam int VAL_W      = 32;
    localparam int W          = 48;
    localparam int ROW_W      = 4 * W;
    localparam int CB_W       = 2 * W;
    localparam int PROD_W     = 2 * W;
    localparam int MUL_CHUNK  = 16;
    localparam int MUL_STEPS  = W / MUL_CHUNK;
    localparam int DIVW       = W + FRAC_BITS + 1;
    localparam int ACNT_W     = $clog2(DIVW + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic signed [W-1:0] W_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] W_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_FX = W'(64'd1 << FRAC_BITS);
    localparam logic [PROD_W-1:0]   HALF_LSB = PROD_W'(64'd1 << (FRAC_BITS - 1));

    // command codes
    localparam logic [1:0] CMD_CELL  = 2'd0;
    localparam logic [1:0] CMD_ENTRY = 2'd1;
    localparam logic [1:0] CMD_SOLVE = 2'd2;

    // entry neighbour codes
    localparam logic [1:0] REL_SAME  = 2'd0;
    localparam logic [1:0] REL_PREV  = 2'd1;
    localparam logic [1:0] REL_NEXT  = 2'd2;
    localparam logic [1:0] REL_OTHER = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PLANE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_PINNED_ENABLE = 2'd1;
    localparam logic [1:0] CFG_PINNED_PLANE  = 2'd2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [PLANE_W-1:0]      plane;
        logic signed [VAL_W-1:0] value;
        logic [1:0]              relation;
        logic                    open_cell;
    } in_item_t;

    typedef struct packed {
        logic [PLANE_W-1:0]      out_plane;
        logic signed [VAL_W-1:0] correction;
        logic                    overflow;
        logic                    last;
    } result_t;

    typedef enum logic [1:0] {
        OP_CELL  = 2'd0,
        OP_ENTRY = 2'd1,
        OP_SOLVE = 2'd2
    } op_t;

    // row layout: diag lowest, then lower, upper, rhs
    typedef enum logic [1:0] {
        FLD_DIAG  = 2'd0,
        FLD_LOWER = 2'd1,
        FLD_UPPER = 2'd2,
        FLD_RHS   = 2'd3
    } fld_t;

    typedef struct packed {
        op_t                     op;
        logic [PLANE_W-1:0]      plane;
        logic signed [VAL_W-1:0] value;
        fld_t                    fld;
        logic                    fix;
    } work_t;

    typedef struct packed {
        logic                start;
        logic                is_div;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic                done;
        logic signed [W-1:0] res;
        logic                ovf;
    } alu_rsp_t;

    function automatic logic sat_hit(input logic signed [W:0] v);
        return v[W] != v[W-1];
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] v);
        if (v[W] != v[W-1])
            return v[W] ? W_MIN : W_MAX;
        return v[W-1:0];
    endfunction

    function automatic logic clip_hit(input logic signed [W-1:0] v);
        return !((&v[W-1:VAL_W-1]) || !(|v[W-1:VAL_W-1]));
    endfunction

    function automatic logic signed [VAL_W-1:0] clip_val(input logic signed [W-1:0] v);
        if (clip_hit(v))
            return v[W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return v[VAL_W-1:0];
    endfunction

endpackage

/* hdl/pstsu_ram.sv */
module pstsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/pstsu_front.sv */
module pstsu_front import pstsu_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  in_item_t           item,
    input  logic               pinned_enable,
    input  logic [PLANE_W-1:0] pinned_plane,
    output logic               head_valid,
    output work_t              head,
    input  logic               take
);

    work_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    cnt_reg, cnt_next;
    work_t              w;
    logic               keep;
    logic               enq;

    // classify: items that change nothing are dropped here
    always_comb
    begin
        w.op    = OP_CELL;
        w.plane = item.plane;
        w.value = item.value;
        w.fld   = FLD_RHS;
        w.fix   = item.open_cell || (pinned_enable && (item.plane == pinned_plane));
        keep    = 1'b1;
        unique case (item.cmd)
            CMD_CELL:
            begin
                w.op  = OP_CELL;
                w.fld = FLD_RHS;
            end
            CMD_ENTRY:
            begin
                w.op = OP_ENTRY;
                unique case (item.relation)
                    REL_SAME:  w.fld = FLD_DIAG;
                    REL_PREV:  w.fld = FLD_LOWER;
                    REL_NEXT:  w.fld = FLD_UPPER;
                    REL_OTHER:
                    begin
                        w.fld = FLD_DIAG;
                        keep  = !item.value[VAL_W-1] && (item.value != '0);
                    end
                    default:   keep = 1'b0;
                endcase
            end
            CMD_SOLVE: w.op = OP_SOLVE;
            default:   keep = 1'b0;
        endcase
    end

    assign full       = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign enq        = push && !full && keep;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QPTR_W+1)'(enq) - (QPTR_W+1)'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            q_reg[wr_ptr_reg] <= w;
    end

endmodule

/* hdl/pstsu_alu.sv */
module pstsu_alu import pstsu_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MUL  = 5'b00010,
        A_RND  = 5'b00100,
        A_DIV  = 5'b01000,
        A_FIN  = 5'b10000
    } astate_t;

    astate_t                 state_reg, state_next;
    logic [ACNT_W-1:0]       cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;
    logic [W-1:0]            ua_reg, ua_next;
    logic [W-1:0]            ub_reg, ub_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [DIVW-1:0]         dvd_reg, dvd_next;
    logic [W-1:0]            rem_reg, rem_next;
    logic [DIVW-1:0]         q_reg, q_next;
    logic                    done_reg, done_next;
    logic signed [W-1:0]     res_reg, res_next;
    logic                    ovf_reg, ovf_next;

    logic [W-1:0]            ma, mb;
    logic [W+MUL_CHUNK-1:0]  prod_step;
    logic [PROD_W-1:0]       rnd;
    logic [W:0]              rem_sh;
    logic                    ge;
    logic                    big;
    logic [W-1:0]            mres;

    assign ma = req.a[W-1] ? W'(-req.a) : W'(req.a);
    assign mb = req.b[W-1] ? W'(-req.b) : W'(req.b);

    assign prod_step = (W+MUL_CHUNK)'(ua_reg) * (W+MUL_CHUNK)'(ub_reg[W-1 -: MUL_CHUNK]);
    assign rnd       = (acc_reg + HALF_LSB) >> FRAC_BITS;
    assign rem_sh    = {rem_reg, dvd_reg[DIVW-1]};
    assign ge        = rem_sh >= {1'b0, ub_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        acc_next   = acc_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        ovf_next   = ovf_reg;
        big        = 1'b0;
        mres       = '0;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    neg_next = req.a[W-1] ^ req.b[W-1];
                    ua_next  = ma;
                    ub_next  = mb;
                    if (!req.is_div)
                    begin
                        acc_next   = '0;
                        cnt_next   = ACNT_W'(MUL_STEPS);
                        state_next = A_MUL;
                    end
                    else if (req.b == '0)
                    begin
                        // zero pivot
                        done_next = 1'b1;
                        ovf_next  = 1'b1;
                        if (req.a == '0)
                            res_next = '0;
                        else
                            res_next = req.a[W-1] ? -W_MAX : W_MAX;
                    end
                    else
                    begin
                        dvd_next   = (DIVW'(ma) << FRAC_BITS) + DIVW'(mb >> 1);
                        rem_next   = '0;
                        q_next     = '0;
                        cnt_next   = ACNT_W'(DIVW);
                        state_next = A_DIV;
                    end
                end
            end
            A_MUL:
            begin
                // top chunk first, so the accumulator shifts left
                acc_next = (acc_reg << MUL_CHUNK) + PROD_W'(prod_step);
                ub_next  = ub_reg << MUL_CHUNK;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == ACNT_W'(1))
                    state_next = A_RND;
            end
            A_RND:
            begin
                big        = (rnd[PROD_W-1:W-1] != '0);
                mres       = big ? W'(W_MAX) : rnd[W-1:0];
                res_next   = neg_reg ? -$signed(mres) : $signed(mres);
                ovf_next   = big;
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            A_DIV:
            begin
                rem_next = ge ? W'(rem_sh - {1'b0, ub_reg}) : rem_sh[W-1:0];
                q_next   = {q_reg[DIVW-2:0], ge};
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == ACNT_W'(1))
                    state_next = A_FIN;
            end
            A_FIN:
            begin
                big        = (q_reg[DIVW-1:W-1] != '0);
                mres       = big ? W'(W_MAX) : q_reg[W-1:0];
                res_next   = neg_reg ? -$signed(mres) : $signed(mres);
                ovf_next   = big;
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        acc_reg <= acc_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        res_reg <= res_next;
        ovf_reg <= ovf_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;
    assign rsp.ovf  = ovf_reg;

endmodule

/* hdl/pstsu_back.sv */
module pstsu_back import pstsu_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  work_t              head,
    output logic               head_take,
    input  logic [CNT_W-1:0]   n_planes,
    output alu_req_t           alu_req,
    input  alu_rsp_t           alu_rsp,
    output logic               empty,
    input  logic               pop,
    output result_t            result
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_LD_WR   = 13'b0000000000010,
        S_FW_RD   = 13'b0000000000100,
        S_FW_LAT  = 13'b0000000001000,
        S_FW_MUL1 = 13'b0000000010000,
        S_FW_MUL2 = 13'b0000000100000,
        S_FW_DIV1 = 13'b0000001000000,
        S_FW_DIV2 = 13'b0000010000000,
        S_BK_RD   = 13'b0000100000000,
        S_BK_LAT  = 13'b0001000000000,
        S_BK_MUL  = 13'b0010000000000,
        S_EM_RD   = 13'b0100000000000,
        S_EM_OUT  = 13'b1000000000000
    } bstate_t;

    bstate_t              state_reg, state_next;
    work_t                cur_reg, cur_next;
    logic [PLANES-1:0]    row_valid_reg, row_valid_next;
    logic [PLANES-1:0]    fixed_reg, fixed_next;
    logic                 cell_skip_reg, cell_skip_next;
    logic                 ovf_reg, ovf_next;
    logic                 rvalid_reg;
    logic [PLANE_W-1:0]   j_reg, j_next;
    logic                 issue_reg, issue_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;
    logic signed [W-1:0]  dg_reg, dg_next;
    logic signed [W-1:0]  lo_reg, lo_next;
    logic signed [W-1:0]  up_reg, up_next;
    logic signed [W-1:0]  rhs_reg, rhs_next;
    logic signed [W-1:0]  d_reg, d_next;
    logic signed [W-1:0]  num_reg, num_next;
    logic signed [W-1:0]  cp_reg, cp_next;
    logic signed [W-1:0]  bb_reg, bb_next;
    logic signed [W-1:0]  sol_reg, sol_next;

    logic [PLANE_W-1:0]   last_idx;
    logic [PLANE_W-1:0]   sum_raddr;
    logic [ROW_W-1:0]     sum_rdata, row_rd, row_new;
    logic                 sum_we;
    logic                 cb_we;
    logic [CB_W-1:0]      cb_wdata, cb_rdata;
    logic                 sol_we;
    logic [VAL_W-1:0]     sol_wdata, sol_rdata;
    logic signed [W-1:0]  old_fld, dg_val;
    logic signed [W:0]    ld_sum, ar_sum;

    assign last_idx  = PLANE_W'(n_planes - CNT_W'(1));
    assign sum_raddr = (state_reg == S_IDLE) ? head.plane : j_reg;
    assign row_rd    = rvalid_reg ? sum_rdata : '0;

    pstsu_ram #(.WIDTH(ROW_W), .DEPTH(PLANES)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (cur_reg.plane),
        .wdata (row_new),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    pstsu_ram #(.WIDTH(CB_W), .DEPTH(PLANES)) u_cb_ram (
        .clk   (clk),
        .we    (cb_we),
        .waddr (j_reg),
        .wdata (cb_wdata),
        .raddr (j_reg),
        .rdata (cb_rdata)
    );

    pstsu_ram #(.WIDTH(VAL_W), .DEPTH(PLANES)) u_sol_ram (
        .clk   (clk),
        .we    (sol_we),
        .waddr (j_reg),
        .wdata (sol_wdata),
        .raddr (j_reg),
        .rdata (sol_rdata)
    );

    // load read-modify-write
    always_comb
    begin
        unique case (cur_reg.fld)
            FLD_DIAG:  old_fld = row_rd[0*W +: W];
            FLD_LOWER: old_fld = row_rd[1*W +: W];
            FLD_UPPER: old_fld = row_rd[2*W +: W];
            default:   old_fld = row_rd[3*W +: W];
        endcase
        ld_sum  = {old_fld[W-1], old_fld}
                + {{(W+1-VAL_W){cur_reg.value[VAL_W-1]}}, cur_reg.value};
        row_new = row_rd;
        unique case (cur_reg.fld)
            FLD_DIAG:  row_new[0*W +: W] = sat_w(ld_sum);
            FLD_LOWER: row_new[1*W +: W] = sat_w(ld_sum);
            FLD_UPPER: row_new[2*W +: W] = sat_w(ld_sum);
            default:   row_new[3*W +: W] = sat_w(ld_sum);
        endcase
        // a fixing cell turns its plane into the identity row
        if (cur_reg.op == OP_CELL && cur_reg.fix)
            row_new = {{(3*W){1'b0}}, ONE_FX};
    end

    assign dg_val = (row_rd[W-1:0] == '0) ? ONE_FX : $signed(row_rd[W-1:0]);

    always_comb
    begin
        alu_req.start  = issue_reg;
        alu_req.is_div = (state_reg == S_FW_DIV1) || (state_reg == S_FW_DIV2);
        unique case (state_reg)
            S_FW_MUL1: begin alu_req.a = lo_reg;  alu_req.b = cp_reg;  end
            S_FW_MUL2: begin alu_req.a = lo_reg;  alu_req.b = bb_reg;  end
            S_FW_DIV1: begin alu_req.a = num_reg; alu_req.b = d_reg;   end
            S_FW_DIV2: begin alu_req.a = up_reg;  alu_req.b = d_reg;   end
            default:   begin alu_req.a = cp_reg;  alu_req.b = sol_reg; end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        row_valid_next = row_valid_reg;
        fixed_next     = fixed_reg;
        cell_skip_next = cell_skip_reg;
        ovf_next       = ovf_reg;
        j_next         = j_reg;
        issue_next     = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        dg_next        = dg_reg;
        lo_next        = lo_reg;
        up_next        = up_reg;
        rhs_next       = rhs_reg;
        d_next         = d_reg;
        num_next       = num_reg;
        cp_next        = cp_reg;
        bb_next        = bb_reg;
        sol_next       = sol_reg;
        head_take      = 1'b0;
        sum_we         = 1'b0;
        cb_we          = 1'b0;
        cb_wdata       = {W'(-alu_rsp.res), bb_reg};
        sol_we         = 1'b0;
        sol_wdata      = clip_val(alu_rsp.res);
        ar_sum         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    head_take = 1'b1;
                    cur_next  = head;
                    unique case (head.op)
                        OP_CELL:
                        begin
                            cell_skip_next = fixed_reg[head.plane];
                            if (!fixed_reg[head.plane])
                                state_next = S_LD_WR;
                        end
                        OP_ENTRY:
                        begin
                            if (!cell_skip_reg)
                                state_next = S_LD_WR;
                        end
                        OP_SOLVE:
                        begin
                            j_next     = '0;
                            state_next = S_FW_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_LD_WR:
            begin
                sum_we   = 1'b1;
                ovf_next = ovf_reg || sat_hit(ld_sum);
                row_valid_next[cur_reg.plane] = 1'b1;
                if (cur_reg.op == OP_CELL && cur_reg.fix)
                    fixed_next[cur_reg.plane] = 1'b1;
                state_next = S_IDLE;
            end
            S_FW_RD: state_next = S_FW_LAT;
            S_FW_LAT:
            begin
                dg_next    = dg_val;
                lo_next    = row_rd[1*W +: W];
                up_next    = row_rd[2*W +: W];
                rhs_next   = row_rd[3*W +: W];
                issue_next = 1'b1;
                if (j_reg == '0)
                begin
                    d_next     = dg_val;
                    num_next   = row_rd[3*W +: W];
                    state_next = S_FW_DIV1;
                end
                else
                    state_next = S_FW_MUL1;
            end
            S_FW_MUL1:
            begin
                if (alu_rsp.done)
                begin
                    ar_sum     = {dg_reg[W-1], dg_reg} + {alu_rsp.res[W-1], alu_rsp.res};
                    d_next     = sat_w(ar_sum);
                    ovf_next   = ovf_reg || alu_rsp.ovf || sat_hit(ar_sum);
                    issue_next = 1'b1;
                    state_next = S_FW_MUL2;
                end
            end
            S_FW_MUL2:
            begin
                if (alu_rsp.done)
                begin
                    ar_sum     = {rhs_reg[W-1], rhs_reg} - {alu_rsp.res[W-1], alu_rsp.res};
                    num_next   = sat_w(ar_sum);
                    ovf_next   = ovf_reg || alu_rsp.ovf || sat_hit(ar_sum);
                    issue_next = 1'b1;
                    state_next = S_FW_DIV1;
                end
            end
            S_FW_DIV1:
            begin
                if (alu_rsp.done)
                begin
                    ovf_next = ovf_reg || alu_rsp.ovf;
                    if (j_reg == last_idx)
                    begin
                        // final plane: start of back substitution
                        sol_next = alu_rsp.res;
                        sol_we   = 1'b1;
                        ovf_next = ovf_reg || alu_rsp.ovf || clip_hit(alu_rsp.res);
                        if (j_reg == '0)
                            state_next = S_EM_RD;
                        else
                        begin
                            j_next     = j_reg - 1'b1;
                            state_next = S_BK_RD;
                        end
                    end
                    else
                    begin
                        bb_next    = alu_rsp.res;
                        issue_next = 1'b1;
                        state_next = S_FW_DIV2;
                    end
                end
            end
            S_FW_DIV2:
            begin
                if (alu_rsp.done)
                begin
                    cp_next    = -alu_rsp.res;
                    cb_we      = 1'b1;
                    ovf_next   = ovf_reg || alu_rsp.ovf;
                    j_next     = j_reg + 1'b1;
                    state_next = S_FW_RD;
                end
            end
            S_BK_RD: state_next = S_BK_LAT;
            S_BK_LAT:
            begin
                cp_next    = cb_rdata[CB_W-1:W];
                bb_next    = cb_rdata[W-1:0];
                issue_next = 1'b1;
                state_next = S_BK_MUL;
            end
            S_BK_MUL:
            begin
                if (alu_rsp.done)
                begin
                    ar_sum    = {bb_reg[W-1], bb_reg} + {alu_rsp.res[W-1], alu_rsp.res};
                    sol_next  = sat_w(ar_sum);
                    sol_we    = 1'b1;
                    sol_wdata = clip_val(sat_w(ar_sum));
                    ovf_next  = ovf_reg || alu_rsp.ovf || sat_hit(ar_sum)
                             || clip_hit(sat_w(ar_sum));
                    if (j_reg == '0)
                        state_next = S_EM_RD;
                    else
                    begin
                        j_next     = j_reg - 1'b1;
                        state_next = S_BK_RD;
                    end
                end
            end
            S_EM_RD: state_next = S_EM_OUT;
            S_EM_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next      = 1'b1;
                    out_next.out_plane  = j_reg;
                    out_next.correction = $signed(sol_rdata);
                    out_next.overflow   = ovf_reg;
                    out_next.last       = (j_reg == last_idx);
                    if (j_reg == last_idx)
                    begin
                        // ready for the next load
                        row_valid_next = '0;
                        fixed_next     = '0;
                        cell_skip_next = 1'b0;
                        ovf_next       = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_EM_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            fixed_reg     <= '0;
            cell_skip_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            rvalid_reg    <= 1'b0;
            j_reg         <= '0;
            issue_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            fixed_reg     <= fixed_next;
            cell_skip_reg <= cell_skip_next;
            ovf_reg       <= ovf_next;
            rvalid_reg    <= row_valid_reg[sum_raddr];
            j_reg         <= j_next;
            issue_reg     <= issue_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
        dg_reg  <= dg_next;
        lo_reg  <= lo_next;
        up_reg  <= up_next;
        rhs_reg <= rhs_next;
        d_reg   <= d_next;
        num_reg <= num_next;
        cp_reg  <= cp_next;
        bb_reg  <= bb_next;
        sol_reg <= sol_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

/* hdl/plane_summed_tridiagonal_solver_unit.sv */
// Load items (cell, entry): one read-modify-write of a plane row each in the back end.
// Solve: per plane forward a row read, two multiplies (none on the first plane) and two divides
// (one on the final plane), then per plane back a coefficient read and one multiply, then the
// emitted results; the pace is set by the shared serial divider.
// Input queue of 2 items and a result register keep both sides running on their own.
// Reset (rst_n, async, active low): plane_count 1, pin off, all sums and flags clear at once.
`include "assert_macros.svh"

module plane_summed_tridiagonal_solver_unit import pstsu_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    // input queue side
    input  logic                  push,
    output logic                  full,
    input  in_item_t              item,
    // result queue side
    output logic                  empty,
    input  logic                  pop,
    output result_t               result,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CNT_W-1:0]   plane_count_reg;
    logic               pinned_enable_reg;
    logic [PLANE_W-1:0] pinned_plane_reg;
    logic [CNT_W-1:0]   n_planes;
    logic [CNT_W-1:0]   n_last;

    logic               head_valid;
    work_t              head;
    logic               head_take;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    // Config registers; the user must write them only while nothing is in flight; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg   <= CNT_W'(1);
            pinned_enable_reg <= 1'b0;
            pinned_plane_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PLANE_COUNT:   plane_count_reg   <= CNT_W'(cfg_data);
                CFG_PINNED_ENABLE: pinned_enable_reg <= cfg_data[0];
                CFG_PINNED_PLANE:  pinned_plane_reg  <= cfg_data[PLANE_W-1:0];
                default:           pinned_plane_reg  <= pinned_plane_reg;
            endcase
        end
    end

    // Plane count clamped: zero counts as one, the top at the plane capacity.
    always_comb
    begin
        if (plane_count_reg == '0)
            n_planes = CNT_W'(1);
        else if (plane_count_reg > CNT_W'(PLANES))
            n_planes = CNT_W'(PLANES);
        else
            n_planes = plane_count_reg;
    end

    assign n_last = n_planes - CNT_W'(1);

    // Front end: classifies each transfer, drops the no-op ones, queues the rest.
    pstsu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .pinned_enable (pinned_enable_reg),
        .pinned_plane  (pinned_plane_reg),
        .head_valid    (head_valid),
        .head          (head),
        .take          (head_take)
    );

    // Back end: plane row memories, Thomas sweep sequencer, result register.
    pstsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_take  (head_take),
        .n_planes   (n_planes),
        .alu_req    (alu_req),
        .alu_rsp    (alu_rsp),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    // Shared multi-cycle multiply (three 16-bit chunks) and radix-2 divide.
    pstsu_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    `CHK_PROP(a_plane_in_range, clk, rst_n, (!empty |-> ({1'b0, result.out_plane} < n_planes)), "result plane beyond plane count")
    `CHK_PROP(a_last_on_final, clk, rst_n, ((!empty && result.last) |-> ({1'b0, result.out_plane} == n_last)), "last flag off the final plane")
    `CHK_PROP(a_gap_after_last, clk, rst_n, ((pop && !empty && result.last) |=> empty), "result straight after the final plane")

endmodule
